// File: hdl/cbrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbrc_pkg;

  // Field widths of one transaction
  localparam int POS_W  = 12;
  localparam int CNT_W  = 13;
  localparam int RUN_W  = CNT_W + 1;

  // Bitmap row geometry: one memory row holds WORD_BITS marks
  localparam int WORD_BITS = 8;
  localparam int LWB       = $clog2(WORD_BITS);

  localparam int DEF_MAX_POSITIONS = 4096;

  // Operation codes
  localparam logic OP_FILL  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic clear;   // write a zero row during the clearing pass
    logic load;    // capture an accepted transaction
    logic issue;   // read the next row
    logic proc;    // work on the row read last cycle
    logic emit;    // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at last row
    logic rd_last;    // read pointer at last row of the range
    logic proc_last;  // row being worked on is the last one
    logic hit;        // this row completes the required run
    logic is_check;   // current transaction is a check
    logic imm;        // incoming transaction needs no scan
  } sts_t;

endpackage : cbrc_pkg

`default_nettype wire

// File: hdl/coverage_bitmap_run_check.sv
//  channel | signals                                              | moves
//  --------+------------------------------------------------------+-----------------
//  in      | in_valid, in_ready, operation, first_pos, fill_count, | one fill or check
//          | last_pos, needed_run, bit_value                      |
//  out     | out_valid, out_ready, run_found                      | one result
//
//  After reset a clearing pass zeroes the bitmap, one 8-bit row a cycle; no
//  transaction is taken then. Rows of a transaction are read once a cycle and
//  worked on the next, through the single read port of the store. Empty ranges
//  and checks with a zero needed run need no row scan; a check stops at its hit.
//  A result waits in the output register; a new transaction is taken meanwhile
//  and holds at its end until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module coverage_bitmap_run_check #(
  parameter int MAX_POSITIONS = cbrc_pkg::DEF_MAX_POSITIONS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       operation,
  input  wire logic [cbrc_pkg::POS_W-1:0] first_pos,
  input  wire logic [cbrc_pkg::CNT_W-1:0] fill_count,
  input  wire logic [cbrc_pkg::POS_W-1:0] last_pos,
  input  wire logic [cbrc_pkg::CNT_W-1:0] needed_run,
  input  wire logic                       bit_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            run_found
);
  import cbrc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  cbrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Bitmap store, range walk and run counter
  cbrc_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (operation),
    .first_pos  (first_pos),
    .fill_count (fill_count),
    .last_pos   (last_pos),
    .needed_run (needed_run),
    .bit_value  (bit_value),
    .run_found  (run_found)
  );

endmodule : coverage_bitmap_run_check

`default_nettype wire

// File: hdl/cbrc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cbrc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire cbrc_pkg::sts_t sts,
  output cbrc_pkg::cmd_t     cmd
);
  import cbrc_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  logic   issuing;   // row reads still to go out
  logic   pvalid;    // a row read is in the data register
  logic   slot_free;
  logic   stop;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign stop      = pvalid && (sts.proc_last || (sts.is_check && sts.hit));

  // Commands
  always_comb begin
    cmd       = '0;
    cmd.clear = (state == S_CLEAR);
    cmd.load  = (state == S_IDLE) && in_valid;
    cmd.issue = (state == S_SCAN) && issuing;
    cmd.proc  = (state == S_SCAN) && pvalid;
    cmd.emit  = (state == S_FINISH) && slot_free;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      issuing   <= 1'b0;
      pvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Output register: fills on emit, empties on acceptance
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (sts.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (sts.imm) begin
              state <= S_FINISH;
            end else begin
              state   <= S_SCAN;
              issuing <= 1'b1;
              pvalid  <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (stop) begin
            state   <= S_FINISH;
            issuing <= 1'b0;
            pvalid  <= 1'b0;
          end else begin
            pvalid  <= issuing;
            issuing <= issuing && !sts.rd_last;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : cbrc_ctrl

`default_nettype wire

// File: hdl/cbrc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cbrc_datapath #(
  parameter int MAX_POSITIONS = cbrc_pkg::DEF_MAX_POSITIONS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cbrc_pkg::cmd_t             cmd,
  output cbrc_pkg::sts_t                  sts,
  input  wire logic                       operation,
  input  wire logic [cbrc_pkg::POS_W-1:0] first_pos,
  input  wire logic [cbrc_pkg::CNT_W-1:0] fill_count,
  input  wire logic [cbrc_pkg::POS_W-1:0] last_pos,
  input  wire logic [cbrc_pkg::CNT_W-1:0] needed_run,
  input  wire logic                       bit_value,
  output logic                            run_found
);
  import cbrc_pkg::*;

  localparam int PW   = $clog2(MAX_POSITIONS);
  localparam int RW   = PW - LWB;
  localparam int ROWS = 1 << RW;
  localparam int EW   = (PW + 1 > CNT_W + 1) ? PW + 1 : CNT_W + 1;
  localparam logic [EW-1:0] MAXP   = EW'(MAX_POSITIONS);
  localparam logic [RW-1:0] LAST_R = RW'(ROWS - 1);

  // Bitmap store
  logic [WORD_BITS-1:0] mem [ROWS];
  logic [WORD_BITS-1:0] rdata;

  // Transaction registers
  logic             op_r;
  logic             bit_r;
  logic [CNT_W-1:0] need_r;
  logic [PW-1:0]    lo;
  logic [PW-1:0]    hi;
  logic [RW-1:0]    rd_row;
  logic [RW-1:0]    proc_row;
  logic [RW-1:0]    clr_row;
  logic [RUN_W-1:0] run_cnt;
  logic             found;

  // Range set-up from the incoming transaction
  logic [EW-1:0] fp_e, lp_e, stop_e, stop_c, hi_f, hi_c;
  logic          empty, imm_val;
  logic [PW-1:0] hi_in;

  always_comb begin
    fp_e   = EW'(first_pos);
    lp_e   = EW'(last_pos);
    stop_e = fp_e + EW'(fill_count);
    stop_c = (stop_e > MAXP) ? MAXP : stop_e;
    hi_f   = stop_c - 1'b1;
    hi_c   = (lp_e >= MAXP) ? (MAXP - 1'b1) : lp_e;
    if (operation == OP_FILL) begin
      empty = (fill_count == '0) || (fp_e >= MAXP);
      hi_in = hi_f[PW-1:0];
    end else begin
      empty = (first_pos > last_pos) || (fp_e >= MAXP);
      hi_in = hi_c[PW-1:0];
    end
    imm_val = !empty && (operation == OP_CHECK) && (needed_run == '0);
  end

  // Row mask and run search over one row
  logic [WORD_BITS-1:0] mask;
  logic [RUN_W-1:0]     run_v;
  logic                 hit_v;
  logic [WORD_BITS-1:0] fill_word;

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      mask[k] = ((proc_row != lo[PW-1:LWB]) || (LWB'(k) >= lo[LWB-1:0])) &&
                ((proc_row != hi[PW-1:LWB]) || (LWB'(k) <= hi[LWB-1:0]));
    end
    run_v = run_cnt;
    hit_v = 1'b0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (mask[k]) begin
        if (rdata[k] == bit_r) begin
          run_v = run_v + 1'b1;
        end else begin
          run_v = '0;
        end
        if (run_v >= RUN_W'(need_r)) begin
          hit_v = 1'b1;
        end
      end
    end
    fill_word = (rdata & ~mask) | (bit_r ? mask : '0);
  end

  always_comb begin
    sts           = '0;
    sts.clr_last  = (clr_row == LAST_R);
    sts.rd_last   = (rd_row == hi[PW-1:LWB]);
    sts.proc_last = (proc_row == hi[PW-1:LWB]);
    sts.hit       = hit_v;
    sts.is_check  = (op_r == OP_CHECK);
    sts.imm       = empty || imm_val;
  end

  // Memory ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_row] <= '0;
    end else if (cmd.proc && (op_r == OP_FILL)) begin
      mem[proc_row] <= fill_word;
    end
    if (cmd.issue) begin
      rdata <= mem[rd_row];
    end
  end

  // Clearing pass pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clear) begin
      clr_row <= clr_row + 1'b1;
    end
  end

  // Walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= operation;
      bit_r   <= bit_value;
      need_r  <= needed_run;
      lo      <= PW'(first_pos) & {PW{!empty}};
      hi      <= hi_in;
      rd_row  <= RW'(first_pos >> LWB);
      run_cnt <= '0;
      found   <= imm_val;
    end else begin
      if (cmd.issue) begin
        proc_row <= rd_row;
        rd_row   <= rd_row + 1'b1;
      end
      if (cmd.proc) begin
        run_cnt <= run_v;
        if ((op_r == OP_CHECK) && hit_v) begin
          found <= 1'b1;
        end
      end
    end
    if (cmd.emit) begin
      run_found <= found;
    end
  end

endmodule : cbrc_datapath

`default_nettype wire

// File: test/coverage_bitmap_run_check_test.sv
`timescale 1ns / 1ps

module coverage_bitmap_run_check_test;
  import cbrc_pkg::*;

  localparam int NUM_MARKS   = DEF_MAX_POSITIONS;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 20;

  // One fill or check transaction
  typedef struct {
    logic             op;
    logic [POS_W-1:0] first;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] last;
    logic [CNT_W-1:0] need;
    logic             mark;
  } query_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             operation = OP_FILL;
  logic [POS_W-1:0] first_pos = '0;
  logic [CNT_W-1:0] fill_count = '0;
  logic [POS_W-1:0] last_pos = '0;
  logic [CNT_W-1:0] needed_run = '0;
  logic             bit_value = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             run_found;

  // Shadow of the coverage store and the results still owed by the block
  logic        marks [NUM_MARKS];
  logic        pending_found [$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;   // no idling on either side while set
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  coverage_bitmap_run_check #(
    .MAX_POSITIONS(NUM_MARKS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .first_pos(first_pos),
    .fill_count(fill_count),
    .last_pos(last_pos),
    .needed_run(needed_run),
    .bit_value(bit_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .run_found(run_found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("coverage_bitmap_run_check_test: errors");
      $finish;
    end
  end

  // Applies one transaction to the shadow store; returns the expected run_found
  function automatic logic apply_query(input query_t q);
    int unsigned stop;
    int unsigned scan_end;
    int unsigned p;
    int unsigned run;
    if (q.op == OP_FILL) begin
      stop = q.first + q.count;
      if (stop > NUM_MARKS) stop = NUM_MARKS;
      for (p = q.first; p < stop; p++) marks[p] = q.mark;
      return 1'b0;
    end
    if (q.first > q.last) return 1'b0;
    scan_end = q.last;
    if (scan_end > NUM_MARKS - 1) scan_end = NUM_MARKS - 1;
    run = 0;
    for (p = q.first; p <= scan_end; p++) begin
      run = (marks[p] == q.mark) ? run + 1 : 0;
      if (run >= q.need) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic query_t make_query(input logic op, input int unsigned first,
                                        input int unsigned count, input int unsigned last,
                                        input int unsigned need, input logic mark);
    query_t q;
    q.op    = op;
    q.first = first[POS_W-1:0];
    q.count = count[CNT_W-1:0];
    q.last  = last[POS_W-1:0];
    q.need  = need[CNT_W-1:0];
    q.mark  = mark;
    return q;
  endfunction

  // Mostly short ranges, now and then a long one or a full-width field
  function automatic query_t random_query(input bit hot);
    query_t      q;
    int unsigned roll;
    int unsigned span;
    int unsigned stop;
    q.op   = ($urandom_range(1) == 0) ? OP_FILL : OP_CHECK;
    q.mark = 1'($urandom_range(1));
    q.first = hot ? POS_W'($urandom_range(0, 255)) : POS_W'($urandom_range(0, NUM_MARKS - 1));
    roll = $urandom_range(99);
    if (roll < 80)      span = $urandom_range(0, 24);
    else if (roll < 95) span = $urandom_range(25, 200);
    else                span = $urandom_range(0, 8191);
    q.count = span[CNT_W-1:0];
    stop = q.first + span;
    if (stop > NUM_MARKS - 1) stop = NUM_MARKS - 1;
    q.last = ($urandom_range(99) < 85) ? POS_W'(stop) : POS_W'($urandom_range(0, NUM_MARKS - 1));
    roll = $urandom_range(99);
    if (roll < 70)      q.need = CNT_W'($urandom_range(0, 12));
    else if (roll < 90) q.need = CNT_W'($urandom_range(13, 64));
    else                q.need = CNT_W'($urandom_range(0, 8191));
    return q;
  endfunction

  // Offers one transaction and records its expected result once accepted.
  // Valid is left high so a following call carries on without a bubble unless it idles at random.
  task automatic send_query(input query_t q);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    operation  <= q.op;
    first_pos  <= q.first;
    fill_count <= q.count;
    last_pos   <= q.last;
    needed_run <= q.need;
    bit_value  <= q.mark;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_found.push_back(apply_query(q));
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // Result checker
  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && out_ready) begin
      if (pending_found.size() == 0) begin
        $display("%0t: result with nothing outstanding, run_found=%0b", $time, run_found);
        errors++;
      end else begin
        want = pending_found.pop_front();
        if (run_found !== want) begin
          $display("%0t: run_found mismatch, expected %0b actual %0b", $time, want, run_found);
          errors++;
        end
      end
    end
  end

  // Field extremes and each corner of fill and check
  task automatic test_directed;
    send_query(make_query(OP_CHECK, 0, 'h1555, 4095, 4096, 1'b0));   // whole store still clear
    send_query(make_query(OP_CHECK, 0, 'h0AAA, 4095, 4097, 1'b0));   // run longer than range
    send_query(make_query(OP_CHECK, 10, 'h1FFF, 9, 0, 1'b0));        // start after end
    send_query(make_query(OP_CHECK, 5, 0, 5, 0, 1'b1));              // zero run, non-empty
    send_query(make_query(OP_FILL, 100, 0, 'hFFF, 'h1FFF, 1'b1));    // zero count
    send_query(make_query(OP_CHECK, 100, 3, 100, 1, 1'b1));
    send_query(make_query(OP_FILL, 4090, 4096, 'h555, 'h0AAA, 1'b1)); // clipped at store end
    send_query(make_query(OP_CHECK, 4088, 0, 4095, 6, 1'b1));
    send_query(make_query(OP_CHECK, 4088, 0, 4095, 7, 1'b1));
    send_query(make_query(OP_CHECK, 4095, 0, 4095, 1, 1'b1));
    send_query(make_query(OP_FILL, 0, 1, 'hAAA, 'h1555, 1'b1));
    send_query(make_query(OP_CHECK, 0, 'h1FFF, 0, 1, 1'b1));
    send_query(make_query(OP_CHECK, 0, 0, 3, 5, 1'b0));
    send_query(make_query(OP_FILL, 4095, 8191, 0, 0, 1'b0));          // widest count
    send_query(make_query(OP_CHECK, 4094, 0, 4095, 1, 1'b0));
    send_query(make_query(OP_CHECK, 0, 0, 4095, 8191, 1'b1));         // widest run
    send_query(make_query(OP_FILL, 0, 4096, 0, 0, 1'b1));             // whole store
    send_query(make_query(OP_CHECK, 0, 0, 4095, 4096, 1'b1));
    send_query(make_query(OP_FILL, 2048, 2048, 0, 0, 1'b0));
    send_query(make_query(OP_CHECK, 2040, 0, 2060, 9, 1'b0));
    send_query(make_query(OP_CHECK, 2040, 0, 2060, 9, 1'b1));
    send_query(make_query(OP_CHECK, 2040, 0, 2060, 8, 1'b1));
    send_query(make_query(OP_FILL, 0, 4096, 0, 0, 1'b0));
    send_query(make_query(OP_CHECK, 'hFFF, 0, 0, 'h1FFF, 1'b1));
  endtask

  // Random fills and checks, mostly in a narrow window so runs form
  task automatic test_random_mix(input int unsigned n);
    repeat (n) send_query(random_query($urandom_range(99) < 70));
  endtask

  // Fill a range, then probe it around the exact run length
  task automatic test_fill_then_probe(input int unsigned n);
    query_t      fill_q;
    int unsigned len;
    int unsigned stop;
    repeat (n) begin
      len  = $urandom_range(1, 32);
      fill_q = make_query(OP_FILL, $urandom_range(0, 255), len, $urandom, $urandom,
                          1'($urandom_range(1)));
      stop = fill_q.first + len - 1;
      send_query(fill_q);
      send_query(make_query(OP_CHECK, fill_q.first, $urandom, stop,
                            len + $urandom_range(0, 1), fill_q.mark));
      send_query(make_query(OP_CHECK, fill_q.first - $urandom_range(0, 4), $urandom,
                            stop + $urandom_range(0, 4), $urandom_range(0, len + 2),
                            1'($urandom_range(1))));
    end
  endtask

  // Receiver holds off for a long stretch while transactions keep coming
  task automatic test_backpressure(input int unsigned n);
    hold_req = 1'b1;
    repeat (n) send_query(random_query(1'b1));
  endtask

  // Back-to-back traffic with no idling either side
  task automatic test_back_to_back(input int unsigned n);
    steady = 1'b1;
    repeat (n) send_query(random_query($urandom_range(99) < 70));
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NUM_MARKS; i++) marks[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(200);
    test_fill_then_probe(50);
    test_backpressure(40);
    test_back_to_back(100);
    test_random_mix(100);
    in_valid <= 1'b0;

    // Drain outstanding results
    while (pending_found.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("coverage_bitmap_run_check_test: clean");
    end else begin
      $display("coverage_bitmap_run_check_test: errors");
    end
    $finish;
  end

endmodule
